// File: sv/cst_pkg.sv
// shared types and constants of the counting semaphore table
`timescale 1ns / 1ps
package cst_pkg;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_POST    = 2'd1,
    CMD_ACQUIRE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_RANGE     = 3'd2,
    ST_UNALLOC   = 3'd3,
    ST_WAITER    = 3'd4,
    ST_NONE_FREE = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    KIND_CREATE,
    KIND_POST,
    KIND_ACQUIRE,
    KIND_RANGE,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  handle;
    logic [15:0] init_count;
    logic [7:0]  task_id;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } head_t;

  localparam int unsigned GROUP_SIZE = 16;
  localparam logic signed [15:0] COUNT_MAX = 16'sd32767;
  localparam logic signed [15:0] COUNT_ZERO = 16'sd0;
  localparam logic signed [15:0] COUNT_ONE = 16'sd1;

endpackage

// File: sv/counting_semaphore_table_unit.sv
// top level of the counting semaphore table
//
//   channel   ports                                           handshake
//   request   cmd_i handle_i init_count_i current_task_i      start_i && !busy_o
//   result    status_o new_handle_o wake_valid_o wake_task_o  done_o, one cycle
//
// post, acquire and bad requests are popped in S_IDLE and then finish in S_EXEC
// create is popped in S_IDLE, then S_SCAN walks the free flags one 16-entry group at a time
// the result is registered out of the final engine state and shows in the cycle after it, for one cycle only
// a two-entry queue takes requests while the engine works; busy_o when full
// reset clears allocated and waiter flags directly, no clearing pass
`timescale 1ns / 1ps
module counting_semaphore_table_unit #(
  parameter int NUM_SEMAPHORES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         handle_i,
  input  logic signed [15:0] init_count_i,
  input  logic [7:0]         current_task_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [3:0]         new_handle_o,
  output logic               wake_valid_o,
  output logic [7:0]         wake_task_o
);

  cst_pkg::head_t head;
  logic           pop;

  cst_front #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .start_i,
    .cmd_i,
    .handle_i,
    .init_count_i,
    .current_task_i,
    .busy_o,
    .head_o (head),
    .pop_i  (pop)
  );

  cst_back #(
    .NUM_SEMAPHORES(NUM_SEMAPHORES)
  ) u_back (
    .clk_i,
    .rst_ni,
    .head_i (head),
    .pop_o  (pop),
    .done_o,
    .status_o,
    .new_handle_o,
    .wake_valid_o,
    .wake_task_o
  );

endmodule

// File: sv/cst_front.sv
// request classifier and two-entry request queue
`timescale 1ns / 1ps
module cst_front #(
  parameter int NUM_SEMAPHORES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [1:0]            cmd_i,
  input  logic [7:0]            handle_i,
  input  logic signed [15:0]    init_count_i,
  input  logic [7:0]            current_task_i,
  output logic                  busy_o,
  output cst_pkg::head_t        head_o,
  input  logic                  pop_i
);

  cst_pkg::op_t entry_q [2];
  cst_pkg::op_t entry_d;
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   fill_q, fill_d;
  logic         push;
  logic         in_range;

  assign in_range = {1'b0, handle_i} < 9'(NUM_SEMAPHORES);

  always_comb begin
    entry_d.handle     = handle_i;
    entry_d.init_count = init_count_i;
    entry_d.task_id    = current_task_i;
    case (cst_pkg::cmd_e'(cmd_i))
      cst_pkg::CMD_CREATE:  entry_d.kind = cst_pkg::KIND_CREATE;
      cst_pkg::CMD_POST:    entry_d.kind = in_range ? cst_pkg::KIND_POST : cst_pkg::KIND_RANGE;
      cst_pkg::CMD_ACQUIRE: entry_d.kind = in_range ? cst_pkg::KIND_ACQUIRE
                                                    : cst_pkg::KIND_RANGE;
      default:              entry_d.kind = cst_pkg::KIND_NOP;
    endcase
  end

  assign busy_o = fill_q == 2'd2;
  assign push   = start_i && !busy_o;

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= entry_d;
    end
  end

  assign head_o.valid = fill_q != 2'd0;
  assign head_o.op    = entry_q[rd_ptr_q];

endmodule

// File: sv/cst_back.sv
// semaphore table and request execution engine
`timescale 1ns / 1ps
module cst_back #(
  parameter int NUM_SEMAPHORES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cst_pkg::head_t     head_i,
  output logic               pop_o,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [3:0]         new_handle_o,
  output logic               wake_valid_o,
  output logic [7:0]         wake_task_o
);

  localparam int IDX_W  = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int GROUPS = (NUM_SEMAPHORES + cst_pkg::GROUP_SIZE - 1) / cst_pkg::GROUP_SIZE;
  localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SCAN_W = GRP_W + 4;
  localparam logic [GRP_W-1:0] LAST_GRP = GRP_W'(GROUPS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  cst_pkg::op_t op_q;

  logic [NUM_SEMAPHORES-1:0] alloc_q;
  logic [NUM_SEMAPHORES-1:0] wv_q;
  logic signed [15:0] cnt_mem [NUM_SEMAPHORES];
  logic [7:0]         task_mem [NUM_SEMAPHORES];
  logic signed [15:0] cnt_rd_q;
  logic [7:0]         task_rd_q;

  logic [GROUPS-1:0][15:0] alloc_grp;
  logic [15:0]        slice;
  logic               slice_free;
  logic [3:0]         pos;
  logic [SCAN_W-1:0]  found_scan;
  logic [IDX_W-1:0]   found_idx;
  logic [IDX_W-1:0]   op_idx;
  logic [IDX_W-1:0]   upd_idx;
  logic [IDX_W-1:0]   rd_idx;

  logic               alloc_set, wv_set, wv_clr;
  logic               cnt_we, task_we;
  logic signed [15:0] cnt_wdata;
  logic signed [15:0] cnt_inc;

  logic               done_d;
  cst_pkg::status_e   status_d;
  logic [3:0]         nh_d;
  logic               wake_d;
  logic [7:0]         wt_d;

  assign op_idx = op_q.handle[IDX_W-1:0];
  assign rd_idx = head_i.op.handle[IDX_W-1:0];

  // entries past the table read as taken
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      for (int b = 0; b < 16; b++) begin
        if (g * 16 + b < NUM_SEMAPHORES) begin
          alloc_grp[g][b] = alloc_q[g * 16 + b];
        end else begin
          alloc_grp[g][b] = 1'b1;
        end
      end
    end
  end

  assign slice      = alloc_grp[grp_q];
  assign slice_free = ~&slice;

  always_comb begin
    pos = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (!slice[i]) begin
        pos = 4'(i);
      end
    end
  end

  assign found_scan = {grp_q, pos};
  assign found_idx  = found_scan[IDX_W-1:0];
  assign upd_idx    = (state_q == S_SCAN) ? found_idx : op_idx;

  assign cnt_inc = (cnt_rd_q < cst_pkg::COUNT_MAX) ? cnt_rd_q + cst_pkg::COUNT_ONE : cnt_rd_q;

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    pop_o     = 1'b0;
    done_d    = 1'b0;
    status_d  = cst_pkg::ST_OK;
    nh_d      = 4'd0;
    wake_d    = 1'b0;
    wt_d      = 8'd0;
    alloc_set = 1'b0;
    wv_set    = 1'b0;
    wv_clr    = 1'b0;
    cnt_we    = 1'b0;
    task_we   = 1'b0;
    cnt_wdata = cnt_rd_q;
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          grp_d = '0;
          state_d = (head_i.op.kind == cst_pkg::KIND_CREATE) ? S_SCAN : S_EXEC;
        end
      end
      S_SCAN: begin
        if (slice_free) begin
          alloc_set = 1'b1;
          wv_clr    = 1'b1;
          cnt_we    = 1'b1;
          cnt_wdata = $signed(op_q.init_count);
          done_d    = 1'b1;
          nh_d      = found_scan[3:0];
          state_d   = S_IDLE;
        end else if (grp_q == LAST_GRP) begin
          done_d   = 1'b1;
          status_d = cst_pkg::ST_NONE_FREE;
          state_d  = S_IDLE;
        end else begin
          grp_d = grp_q + 1'b1;
        end
      end
      S_EXEC: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        case (op_q.kind)
          cst_pkg::KIND_RANGE: status_d = cst_pkg::ST_RANGE;
          cst_pkg::KIND_POST: begin
            if (!alloc_q[op_idx]) begin
              status_d = cst_pkg::ST_UNALLOC;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_inc;
              if (cnt_inc > cst_pkg::COUNT_ZERO && wv_q[op_idx]) begin
                cnt_wdata = cnt_inc - cst_pkg::COUNT_ONE;
                wake_d    = 1'b1;
                wt_d      = task_rd_q;
                wv_clr    = 1'b1;
              end
            end
          end
          cst_pkg::KIND_ACQUIRE: begin
            if (!alloc_q[op_idx]) begin
              status_d = cst_pkg::ST_UNALLOC;
            end else if (wv_q[op_idx]) begin
              status_d = cst_pkg::ST_WAITER;
            end else if (cnt_rd_q <= cst_pkg::COUNT_ZERO) begin
              wv_set   = 1'b1;
              task_we  = 1'b1;
              status_d = cst_pkg::ST_BLOCKED;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rd_q - cst_pkg::COUNT_ONE;
            end
          end
          default: status_d = cst_pkg::ST_OK;
        endcase
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      grp_q   <= '0;
      done_o  <= 1'b0;
      alloc_q <= '0;
      wv_q    <= '0;
    end else begin
      state_q <= state_d;
      grp_q   <= grp_d;
      done_o  <= done_d;
      if (alloc_set) begin
        alloc_q[upd_idx] <= 1'b1;
      end
      if (wv_set) begin
        wv_q[upd_idx] <= 1'b1;
      end else if (wv_clr) begin
        wv_q[upd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q      <= head_i.op;
      cnt_rd_q  <= cnt_mem[rd_idx];
      task_rd_q <= task_mem[rd_idx];
    end
    if (cnt_we) begin
      cnt_mem[upd_idx] <= cnt_wdata;
    end
    if (task_we) begin
      task_mem[upd_idx] <= op_q.task_id;
    end
    status_o     <= status_d;
    new_handle_o <= nh_d;
    wake_valid_o <= wake_d;
    wake_task_o  <= wt_d;
  end

endmodule

// File: sv/cst_checker.sv
// port-level checks of the counting semaphore table and their binding
`timescale 1ns / 1ps
module cst_assert (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_i,
  input logic       done_i,
  input logic [2:0] status_i,
  input logic [3:0] new_handle_i,
  input logic       wake_valid_i
);

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> status_i <= cst_pkg::ST_NONE_FREE)
    else $error("result status code out of range");

  a_wake_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && wake_valid_i |-> status_i == cst_pkg::ST_OK && new_handle_i == 4'd0)
    else $error("wake reported with an error or a handle");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && status_i != cst_pkg::ST_OK |-> !wake_valid_i && new_handle_i == 4'd0)
    else $error("failed request carries wake or handle");

  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_i) |-> $past(start_i))
    else $error("queue filled without a request");

endmodule

bind counting_semaphore_table_unit cst_assert u_cst_assert (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_i       (busy_o),
  .done_i       (done_o),
  .status_i     (status_o),
  .new_handle_i (new_handle_o),
  .wake_valid_i (wake_valid_o)
);

// File: tb/cst_checker.sv
// checker for the counting semaphore table: predicts every result and compares it
`timescale 1ns / 1ps
module cst_checker #(
  parameter int NUM_SEMAPHORES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         handle_i,
  input  logic signed [15:0] init_count_i,
  input  logic [7:0]         current_task_i,
  input  logic               done_i,
  input  logic [2:0]         status_i,
  input  logic [3:0]         new_handle_i,
  input  logic               wake_valid_i,
  input  logic [7:0]         wake_task_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 wakes_o
);

  typedef struct packed {
    cst_pkg::status_e status;
    logic [3:0]       new_handle;
    logic             wake_valid;
    logic [7:0]       wake_task;
  } sem_outcome_t;

  logic               entry_used       [NUM_SEMAPHORES];
  logic signed [15:0] entry_count      [NUM_SEMAPHORES];
  logic               entry_has_waiter [NUM_SEMAPHORES];
  logic [7:0]         entry_waiter     [NUM_SEMAPHORES];

  sem_outcome_t outcome_q[$];
  int           mismatches;
  int           result_count;
  int           wake_count;

  function automatic sem_outcome_t resolve_request(logic [1:0] c, logic [7:0] h,
                                                   logic signed [15:0] ic, logic [7:0] t);
    sem_outcome_t o;
    bit           found;
    o.status     = cst_pkg::ST_OK;
    o.new_handle = '0;
    o.wake_valid = 1'b0;
    o.wake_task  = '0;
    found        = 1'b0;
    case (c)
      cst_pkg::CMD_CREATE: begin
        o.status = cst_pkg::ST_NONE_FREE;
        for (int i = 0; i < NUM_SEMAPHORES; i++) begin
          if (!found && !entry_used[i]) begin
            found               = 1'b1;
            entry_used[i]       = 1'b1;
            entry_count[i]      = ic;
            entry_has_waiter[i] = 1'b0;
            entry_waiter[i]     = '0;
            o.new_handle        = 4'(i);
            o.status            = cst_pkg::ST_OK;
          end
        end
      end
      cst_pkg::CMD_POST, cst_pkg::CMD_ACQUIRE: begin
        if (h >= NUM_SEMAPHORES) begin
          o.status = cst_pkg::ST_RANGE;
        end else if (!entry_used[h]) begin
          o.status = cst_pkg::ST_UNALLOC;
        end else if (c == cst_pkg::CMD_POST) begin
          if (entry_count[h] != cst_pkg::COUNT_MAX) begin
            entry_count[h] = entry_count[h] + cst_pkg::COUNT_ONE;
          end
          if (entry_count[h] > cst_pkg::COUNT_ZERO && entry_has_waiter[h]) begin
            entry_count[h]      = entry_count[h] - cst_pkg::COUNT_ONE;
            o.wake_valid        = 1'b1;
            o.wake_task         = entry_waiter[h];
            entry_has_waiter[h] = 1'b0;
            entry_waiter[h]     = '0;
          end
        end else begin
          if (entry_has_waiter[h]) begin
            o.status = cst_pkg::ST_WAITER;
          end else if (entry_count[h] <= cst_pkg::COUNT_ZERO) begin
            entry_has_waiter[h] = 1'b1;
            entry_waiter[h]     = t;
            o.status            = cst_pkg::ST_BLOCKED;
          end else begin
            entry_count[h] = entry_count[h] - cst_pkg::COUNT_ONE;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sem_outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEMAPHORES; i++) begin
        entry_used[i]       = 1'b0;
        entry_count[i]      = '0;
        entry_has_waiter[i] = 1'b0;
        entry_waiter[i]     = '0;
      end
      outcome_q.delete();
      mismatches   = 0;
      result_count = 0;
      wake_count   = 0;
    end else begin
      if (done_i) begin
        result_count++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] unexpected result: status %0d handle %0d wake %0d task %0d",
                     $realtime, status_i, new_handle_i, wake_valid_i, wake_task_i);
          end
        end else begin
          want = outcome_q.pop_front();
          if (want.wake_valid) wake_count++;
          if (status_i !== want.status || new_handle_i !== want.new_handle ||
              wake_valid_i !== want.wake_valid || wake_task_i !== want.wake_task) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] mismatch: expected status %0d handle %0d wake %0d task %0d",
                       $realtime, want.status, want.new_handle, want.wake_valid,
                       want.wake_task);
              $display("[%0t]           actual   status %0d handle %0d wake %0d task %0d",
                       $realtime, status_i, new_handle_i, wake_valid_i, wake_task_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        outcome_q.push_back(resolve_request(cmd_i, handle_i, init_count_i, current_task_i));
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= outcome_q.size();
    results_o    <= result_count;
    wakes_o      <= wake_count;
  end

endmodule

// File: tb/tb.sv
// testbench top: drives semaphore table requests and reports the verdict
`timescale 1ns / 1ps
module tb;

  localparam int N_SEM       = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic [1:0]         cmd_i          = cst_pkg::CMD_NOP;
  logic [7:0]         handle_i       = '0;
  logic signed [15:0] init_count_i   = '0;
  logic [7:0]         current_task_i = '0;
  logic               busy_o;
  logic               done_o;
  logic [2:0]         status_o;
  logic [3:0]         new_handle_o;
  logic               wake_valid_o;
  logic [7:0]         wake_task_o;

  int fail_count;
  int pending;
  int results;
  int wakes;
  int sent     = 0;
  int cycles   = 0;
  int idle_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  counting_semaphore_table_unit #(
    .NUM_SEMAPHORES(N_SEM)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .cmd_i         (cmd_i),
    .handle_i      (handle_i),
    .init_count_i  (init_count_i),
    .current_task_i(current_task_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .new_handle_o  (new_handle_o),
    .wake_valid_o  (wake_valid_o),
    .wake_task_o   (wake_task_o)
  );

  cst_checker #(
    .NUM_SEMAPHORES(N_SEM)
  ) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .cmd_i         (cmd_i),
    .handle_i      (handle_i),
    .init_count_i  (init_count_i),
    .current_task_i(current_task_i),
    .done_i        (done_o),
    .status_i      (status_o),
    .new_handle_i  (new_handle_o),
    .wake_valid_i  (wake_valid_o),
    .wake_task_i   (wake_task_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results),
    .wakes_o       (wakes)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic issue(input logic [1:0] c, input logic [7:0] h, input logic [15:0] ic,
                       input logic [7:0] t);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cmd_i          <= c;
    handle_i       <= h;
    init_count_i   <= ic;
    current_task_i <= t;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic random_burst(input int n, input int pct);
    int         r;
    logic [1:0] c;
    logic [7:0] h;
    idle_pct = pct;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      c = (r < 44) ? cst_pkg::CMD_POST :
          (r < 90) ? cst_pkg::CMD_ACQUIRE :
          (r < 95) ? cst_pkg::CMD_CREATE : cst_pkg::CMD_NOP;
      h = ($urandom_range(99) < 88) ? 8'($urandom_range(N_SEM - 1))
                                    : 8'($urandom_range(255, N_SEM));
      issue(c, h, 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct = 23;
    // errors and a no-op on an empty table
    issue(cst_pkg::CMD_ACQUIRE, 8'd0, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_POST, 8'd0, 16'hffff, 8'hff);
    issue(cst_pkg::CMD_POST, 8'd16, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_ACQUIRE, 8'd255, 16'hffff, 8'hff);
    issue(cst_pkg::CMD_NOP, 8'hff, 16'hffff, 8'hff);
    // fill the table, extremes of the count first
    issue(cst_pkg::CMD_CREATE, 8'hff, 16'sd0, 8'hff);
    issue(cst_pkg::CMD_CREATE, 8'h00, 16'sd1, 8'h00);
    issue(cst_pkg::CMD_CREATE, 8'hff, -16'sd1, 8'hff);
    issue(cst_pkg::CMD_CREATE, 8'h00, 16'sd32767, 8'h00);
    issue(cst_pkg::CMD_CREATE, 8'hff, -16'sd32768, 8'hff);
    issue(cst_pkg::CMD_CREATE, 8'h00, 16'sd32766, 8'h00);
    for (int i = 6; i < N_SEM; i++) begin
      issue(cst_pkg::CMD_CREATE, 8'($urandom), 16'($signed($urandom_range(5)) - 2),
            8'($urandom));
    end
    issue(cst_pkg::CMD_CREATE, 8'h00, 16'sd7, 8'h00);
    // block, second waiter, wake
    issue(cst_pkg::CMD_ACQUIRE, 8'd0, 16'h0000, 8'haa);
    issue(cst_pkg::CMD_ACQUIRE, 8'd0, 16'h0000, 8'h55);
    issue(cst_pkg::CMD_POST, 8'd0, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_ACQUIRE, 8'd1, 16'h0000, 8'h01);
    // saturation at the top, negative count without wake
    issue(cst_pkg::CMD_POST, 8'd3, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_ACQUIRE, 8'd4, 16'h0000, 8'h44);
    issue(cst_pkg::CMD_POST, 8'd4, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_ACQUIRE, 8'd2, 16'h0000, 8'h22);
    issue(cst_pkg::CMD_POST, 8'd2, 16'h0000, 8'h00);
    issue(cst_pkg::CMD_POST, 8'd2, 16'h0000, 8'h00);

    random_burst(400, 23);
    random_burst(400, 81);
    random_burst(400, 0);
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("sent %0d requests with sender idling at 23%%, 81%% and 0%% of cycles", sent);
    $display("compared %0d results, %0d of them waking a waiting task", results, wakes);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
